// File: sv/rau_pkg.sv
// rau_pkg: shared types and constants of the rational arithmetic unit
// used by rational_arithmetic_unit and its testbench; no dependencies

package rau_pkg;

   // field widths that do not follow the operand width
   localparam int FUNC_BITS     = 2;
   localparam int RESULT_BITS   = 33;
   localparam int RSP_DATA_BITS = ((2 * RESULT_BITS + 7) / 8) * 8;

   // operation codes
   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   // status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_DIV_ZERO = 1'b1;

   // sequencer states, one-hot
   typedef enum logic [13:0] {
      ST_IDLE    = 14'h0001,
      ST_REM_AB  = 14'h0002,
      ST_REM_BA  = 14'h0004,
      ST_DEN_MUL = 14'h0008,
      ST_QA      = 14'h0010,
      ST_TA      = 14'h0020,
      ST_QB      = 14'h0040,
      ST_TB      = 14'h0080,
      ST_MUL_N   = 14'h0100,
      ST_MUL_D   = 14'h0200,
      ST_GCD     = 14'h0400,
      ST_RED_N   = 14'h0800,
      ST_RED_D   = 14'h1000,
      ST_DONE    = 14'h2000
   } state_type;

endpackage

// File: sv/rau_div.sv
// rau_div: shared radix-2 restoring divider with truncating quotient and remainder
// the remainder takes the sign of the dividend; no package dependencies

module rau_div #(
   parameter int WIDTH = 34
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [WIDTH-1:0] dividend,
   input  logic signed [WIDTH-1:0] divisor,
   output logic                    done,
   output logic signed [WIDTH-1:0] quot,
   output logic signed [WIDTH-1:0] rem
);

   localparam int CW = $clog2(WIDTH);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic             neg_q_ff, neg_q_in;
   logic             neg_r_ff, neg_r_in;

   logic [WIDTH-1:0] dnd_mag, dvs_mag;
   logic [WIDTH:0]   trial, diff;

   // operand magnitudes
   assign dnd_mag = dividend[WIDTH-1] ? (~dividend + WIDTH'(1)) : dividend;
   assign dvs_mag = divisor[WIDTH-1]  ? (~divisor + WIDTH'(1))  : divisor;

   // one trial subtraction per cycle
   assign trial = {rem_ff, quo_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CW'(WIDTH - 1);
         rem_in   = '0;
         quo_in   = dnd_mag;
         dvs_in   = dvs_mag;
         neg_q_in = dividend[WIDTH-1] ^ divisor[WIDTH-1];
         neg_r_in = dividend[WIDTH-1];
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   // restore signs
   assign done = done_ff;
   assign quot = neg_q_ff ? $signed(~quo_ff + WIDTH'(1)) : $signed(quo_ff);
   assign rem  = neg_r_ff ? $signed(~rem_ff + WIDTH'(1)) : $signed(rem_ff);

endmodule

// File: sv/rau_mul.sv
// rau_mul: shared signed multiplier with registered product
// no package dependencies

module rau_mul #(
   parameter int WIDTH = 17
) (
   input  logic                      clock,
   input  logic signed [WIDTH-1:0]   mul_a,
   input  logic signed [WIDTH-1:0]   mul_b,
   output logic signed [2*WIDTH-1:0] product
);

   logic signed [2*WIDTH-1:0] product_ff, product_in;

   // full-width signed product
   assign product_in = (2 * WIDTH)'(mul_a) * (2 * WIDTH)'(mul_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// File: sv/rational_arithmetic_unit.sv
// Rational arithmetic unit: adds, subtracts, multiplies or divides two signed
// fractions and reduces the result by a truncating Euclid gcd, whose sign it
// keeps. Zero denominators read as one; dividing by a zero fraction gives 0/1
// with status 1. One item is worked at a time: req_tready is high only while
// the unit is idle. All work runs on one shared multiplier and one shared
// bit-serial divider. An item takes two or three multiplies plus the
// divisions: two checks and two scalings for add and subtract, one per Euclid
// step, and two for the final reduction. A division by a zero fraction skips
// all of these; the time of any other item is set by the number of Euclid steps.
// Depends on rau_pkg, rau_div and rau_mul.

module rational_arithmetic_unit #(
   parameter int OPERAND_BITS = 16
) (
   input  logic clock,
   input  logic reset,

   // request beat; tdata fields from bit 0: func, a_num, a_den, b_num, b_den
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [((rau_pkg::FUNC_BITS + 4 * OPERAND_BITS + 7) / 8) * 8 - 1:0] req_tdata,

   // response beat; tdata fields from bit 0: result_num, result_den
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rau_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // tuser fields from bit 0: status
   output logic [0:0]                          rsp_tuser
);

   localparam int N  = OPERAND_BITS;
   localparam int W  = 2 * N + 2;
   localparam int QW = N + 1;
   localparam int FB = rau_pkg::FUNC_BITS;
   localparam int RB = rau_pkg::RESULT_BITS;

   rau_pkg::state_type state_ff, state_in;
   logic               wait_ff, wait_in;
   rau_pkg::func_type  func_ff, func_in;
   logic signed [N-1:0]  an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic signed [W-1:0]  num_ff, num_in, den_ff, den_in, x_ff, x_in, y_ff, y_in;
   logic signed [QW-1:0] q_ff, q_in;
   logic                 ra_zero_ff, ra_zero_in;
   logic                 status_ff, status_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [RB-1:0] rsp_num_ff, rsp_num_in, rsp_den_ff, rsp_den_in;
   logic          rsp_status_ff, rsp_status_in;

   logic                 req_fire, out_free;
   rau_pkg::func_type    req_func;
   logic signed [N-1:0]  req_an, req_ad, req_bn, req_bd;

   logic                 div_start, div_done;
   logic signed [W-1:0]  div_dividend, div_divisor, div_quot, div_rem;
   logic signed [QW-1:0] mul_a, mul_b;
   logic signed [W-1:0]  mul_p;

   // shared units
   rau_div #(.WIDTH(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   rau_mul #(.WIDTH(QW)) u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (mul_p)
   );

   // request unpacking
   assign req_func = rau_pkg::func_type'(req_tdata[FB-1:0]);
   assign req_an   = req_tdata[FB +: N];
   assign req_ad   = req_tdata[FB + N +: N];
   assign req_bn   = req_tdata[FB + 2 * N +: N];
   assign req_bd   = req_tdata[FB + 3 * N +: N];

   assign req_tready = (state_ff == rau_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      wait_in       = wait_ff;
      func_in       = func_ff;
      an_in         = an_ff;
      ad_in         = ad_ff;
      bn_in         = bn_ff;
      bd_in         = bd_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      q_in          = q_ff;
      ra_zero_in    = ra_zero_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_num_in    = rsp_num_ff;
      rsp_den_in    = rsp_den_ff;
      rsp_status_in = rsp_status_ff;
      div_start     = 1'b0;
      div_dividend  = '0;
      div_divisor   = '0;
      mul_a         = '0;
      mul_b         = '0;

      unique case (state_ff)
         rau_pkg::ST_IDLE: begin
            if (req_fire) begin
               func_in   = req_func;
               an_in     = req_an;
               ad_in     = (req_ad == '0) ? N'(1) : req_ad;
               bn_in     = req_bn;
               bd_in     = (req_bd == '0) ? N'(1) : req_bd;
               status_in = rau_pkg::STATUS_OK;
               wait_in   = 1'b0;
               unique case (req_func)
                  rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: state_in = rau_pkg::ST_REM_AB;
                  rau_pkg::FUNC_MUL: state_in = rau_pkg::ST_MUL_N;
                  rau_pkg::FUNC_DIV: begin
                     if (req_bn == '0) begin
                        num_in    = '0;
                        den_in    = W'(1);
                        status_in = rau_pkg::STATUS_DIV_ZERO;
                        state_in  = rau_pkg::ST_DONE;
                     end else begin
                        state_in = rau_pkg::ST_MUL_N;
                     end
                  end
                  default: state_in = rau_pkg::ST_IDLE;
               endcase
            end
         end

         // does bd divide ad
         rau_pkg::ST_REM_AB: begin
            div_dividend = W'(ad_ff);
            div_divisor  = W'(bd_ff);
            div_start    = !wait_ff;
            wait_in      = 1'b1;
            if (wait_ff && div_done) begin
               ra_zero_in = (div_rem == '0);
               wait_in    = 1'b0;
               state_in   = rau_pkg::ST_REM_BA;
            end
         end

         // does ad divide bd; pick the common denominator
         rau_pkg::ST_REM_BA: begin
            div_dividend = W'(bd_ff);
            div_divisor  = W'(ad_ff);
            div_start    = !wait_ff;
            wait_in      = 1'b1;
            if (wait_ff && div_done) begin
               wait_in = 1'b0;
               if (ra_zero_ff || div_rem == '0) begin
                  den_in   = (ad_ff >= bd_ff) ? W'(ad_ff) : W'(bd_ff);
                  state_in = rau_pkg::ST_QA;
               end else begin
                  state_in = rau_pkg::ST_DEN_MUL;
               end
            end
         end

         rau_pkg::ST_DEN_MUL: begin
            mul_a   = QW'(ad_ff);
            mul_b   = QW'(bd_ff);
            wait_in = 1'b1;
            if (wait_ff) begin
               den_in   = mul_p;
               wait_in  = 1'b0;
               state_in = rau_pkg::ST_QA;
            end
         end

         // scale of first numerator
         rau_pkg::ST_QA: begin
            div_dividend = den_ff;
            div_divisor  = W'(ad_ff);
            div_start    = !wait_ff;
            wait_in      = 1'b1;
            if (wait_ff && div_done) begin
               q_in     = QW'(div_quot);
               wait_in  = 1'b0;
               state_in = rau_pkg::ST_TA;
            end
         end

         rau_pkg::ST_TA: begin
            mul_a   = q_ff;
            mul_b   = QW'(an_ff);
            wait_in = 1'b1;
            if (wait_ff) begin
               num_in   = mul_p;
               wait_in  = 1'b0;
               state_in = rau_pkg::ST_QB;
            end
         end

         // scale of second numerator
         rau_pkg::ST_QB: begin
            div_dividend = den_ff;
            div_divisor  = W'(bd_ff);
            div_start    = !wait_ff;
            wait_in      = 1'b1;
            if (wait_ff && div_done) begin
               q_in     = QW'(div_quot);
               wait_in  = 1'b0;
               state_in = rau_pkg::ST_TB;
            end
         end

         // combine numerators and start the gcd
         rau_pkg::ST_TB: begin
            mul_a   = q_ff;
            mul_b   = QW'(bn_ff);
            wait_in = 1'b1;
            if (wait_ff) begin
               num_in   = (func_ff == rau_pkg::FUNC_SUB) ? (num_ff - mul_p) : (num_ff + mul_p);
               x_in     = num_in;
               y_in     = den_ff;
               wait_in  = 1'b0;
               state_in = rau_pkg::ST_GCD;
            end
         end

         // cross products for multiply and divide
         rau_pkg::ST_MUL_N: begin
            mul_a   = QW'(an_ff);
            mul_b   = (func_ff == rau_pkg::FUNC_DIV) ? QW'(bd_ff) : QW'(bn_ff);
            wait_in = 1'b1;
            if (wait_ff) begin
               num_in   = mul_p;
               wait_in  = 1'b0;
               state_in = rau_pkg::ST_MUL_D;
            end
         end

         rau_pkg::ST_MUL_D: begin
            mul_a   = (func_ff == rau_pkg::FUNC_DIV) ? QW'(bn_ff) : QW'(ad_ff);
            mul_b   = (func_ff == rau_pkg::FUNC_DIV) ? QW'(ad_ff) : QW'(bd_ff);
            wait_in = 1'b1;
            if (wait_ff) begin
               den_in   = mul_p;
               x_in     = num_ff;
               y_in     = mul_p;
               wait_in  = 1'b0;
               state_in = rau_pkg::ST_GCD;
            end
         end

         // one euclid step per division; x holds the gcd at the end
         rau_pkg::ST_GCD: begin
            div_dividend = x_ff;
            div_divisor  = y_ff;
            if (y_ff == '0) begin
               wait_in  = 1'b0;
               state_in = (x_ff == '0) ? rau_pkg::ST_DONE : rau_pkg::ST_RED_N;
            end else begin
               div_start = !wait_ff;
               wait_in   = 1'b1;
               if (wait_ff && div_done) begin
                  x_in    = y_ff;
                  y_in    = div_rem;
                  wait_in = 1'b0;
               end
            end
         end

         rau_pkg::ST_RED_N: begin
            div_dividend = num_ff;
            div_divisor  = x_ff;
            div_start    = !wait_ff;
            wait_in      = 1'b1;
            if (wait_ff && div_done) begin
               num_in   = div_quot;
               wait_in  = 1'b0;
               state_in = rau_pkg::ST_RED_D;
            end
         end

         rau_pkg::ST_RED_D: begin
            div_dividend = den_ff;
            div_divisor  = x_ff;
            div_start    = !wait_ff;
            wait_in      = 1'b1;
            if (wait_ff && div_done) begin
               den_in   = div_quot;
               wait_in  = 1'b0;
               state_in = rau_pkg::ST_DONE;
            end
         end

         // hand the result to the output register
         rau_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_num_in    = RB'(num_ff);
               rsp_den_in    = RB'(den_ff);
               rsp_status_in = status_ff;
               state_in      = rau_pkg::ST_IDLE;
            end
         end

         default: state_in = rau_pkg::ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rau_pkg::ST_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // operands, working values and result
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      an_ff         <= an_in;
      ad_ff         <= ad_in;
      bn_ff         <= bn_in;
      bd_ff         <= bd_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      q_ff          <= q_in;
      ra_zero_ff    <= ra_zero_in;
      status_ff     <= status_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_den_ff    <= rsp_den_in;
      rsp_status_ff <= rsp_status_in;
   end

   // response beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(rau_pkg::RSP_DATA_BITS - 2 * RB)'(0), rsp_den_ff, rsp_num_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
